// File: design/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types and constants for the postfix stack evaluator: character
// codes, operator and state encodings, data width and default stack depth.
// ----------------------------------------------------------------------------
package pse_pkg;

    localparam int DATA_W          = 32;
    localparam int DEF_STACK_DEPTH = 64;

    localparam logic [7:0] CH_END    = 8'h00;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_MUL    = 8'h2A;
    localparam logic [7:0] CH_DIV    = 8'h2F;
    localparam logic [7:0] CH_DIGIT0 = 8'h30;
    localparam logic [7:0] CH_DIGIT9 = 8'h39;

    localparam logic [DATA_W-1:0] EMPTY_READ = '1;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OP_R,
        S_OP_L,
        S_EXEC,
        S_DIV,
        S_PUSH,
        S_TOP,
        S_EMIT
    } t_state;

endpackage

// File: design/pse_ram.sv
// ----------------------------------------------------------------------------
// pse_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pse_ram #(
    parameter int WIDTH = pse_pkg::DATA_W,
    parameter int DEPTH = pse_pkg::DEF_STACK_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/pse_div.sv
// ----------------------------------------------------------------------------
// pse_div
// Iterative signed divider, truncating toward zero. One quotient bit per
// cycle on magnitudes, sign applied at the output. Done pulses after 32 steps.
// ----------------------------------------------------------------------------
module pse_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [pse_pkg::DATA_W-1:0]  i_dividend,
    input  logic [pse_pkg::DATA_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [pse_pkg::DATA_W-1:0]  o_quotient
);

    localparam int W     = pse_pkg::DATA_W;
    localparam int CNT_W = $clog2(W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_mb;
    logic             r_neg;

    logic [W:0]       rem_sh;
    logic [W:0]       diff;
    logic             q_bit;

    assign rem_sh = {r_rem, r_quo[W-1]};
    assign diff   = rem_sh - {1'b0, r_mb};
    assign q_bit  = ~diff[W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend[W-1] ? (W'(0) - i_dividend) : i_dividend;
            r_mb  <= i_divisor[W-1] ? (W'(0) - i_divisor) : i_divisor;
            r_neg <= i_dividend[W-1] ^ i_divisor[W-1];
        end else if (r_busy) begin
            r_rem <= q_bit ? diff[W-1:0] : rem_sh[W-1:0];
            r_quo <= {r_quo[W-2:0], q_bit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (W'(0) - r_quo) : r_quo;

endmodule

// File: design/postfix_stack_evaluator.sv
// One character at a time. Digit or ignored character: S_IDLE. + - *: S_OP_R,
// S_OP_L, S_EXEC, S_PUSH; / also waits in S_DIV, where the divider loop sets
// the worst case. End byte: S_TOP, S_EMIT, held while the output stalls.
// Synchronous active-low reset clears state, count, flags and output valid;
// the stack memory is not cleared.
// ----------------------------------------------------------------------------
// postfix_stack_evaluator
// Postfix integer evaluator over a RAM-backed operand stack with an
// iterative divider and a registered result beat.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator #(
    parameter int STACK_DEPTH = pse_pkg::DEF_STACK_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_char_code,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_value,
    output logic               o_overflow_seen,
    output logic               o_underflow_seen,
    output logic               o_div_zero_seen
);

    localparam int W  = pse_pkg::DATA_W;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    pse_pkg::t_state r_state, n_state;
    pse_pkg::t_op    r_op, n_op;
    logic [CW-1:0]   r_count, n_count;
    logic            r_ovf, n_ovf;
    logic            r_unf, n_unf;
    logic            r_dz, n_dz;
    logic [W-1:0]    r_right, n_right;
    logic [W-1:0]    r_left, n_left;
    logic [W-1:0]    r_res, n_res;
    logic            r_out_valid, n_out_valid;
    logic [W-1:0]    r_out_value, n_out_value;
    logic            r_out_ovf, n_out_ovf;
    logic            r_out_unf, n_out_unf;
    logic            r_out_dz, n_out_dz;

    logic            in_acc;
    logic            is_digit;
    logic            is_op;
    logic            full;
    logic [CW-1:0]   cnt_m1;
    logic [CW-1:0]   cnt_m2;
    logic            ram_we;
    logic [W-1:0]    ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [W-1:0]    ram_rdata;
    logic            div_start;
    logic            div_done;
    logic [W-1:0]    div_q;

    assign in_acc   = i_in_valid && (r_state == pse_pkg::S_IDLE);
    assign is_digit = (i_char_code >= pse_pkg::CH_DIGIT0)
                   && (i_char_code <= pse_pkg::CH_DIGIT9);
    assign is_op    = (i_char_code == pse_pkg::CH_PLUS) || (i_char_code == pse_pkg::CH_MINUS)
                   || (i_char_code == pse_pkg::CH_MUL) || (i_char_code == pse_pkg::CH_DIV);
    assign full     = (r_count == CW'(STACK_DEPTH));
    assign cnt_m1   = r_count - CW'(1);
    assign cnt_m2   = r_count - CW'(2);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_unf       = r_unf;
        n_dz        = r_dz;
        n_right     = r_right;
        n_left      = r_left;
        n_res       = r_res;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_value = r_out_value;
        n_out_ovf   = r_out_ovf;
        n_out_unf   = r_out_unf;
        n_out_dz    = r_out_dz;
        ram_we      = 1'b0;
        ram_wdata   = r_res;
        ram_raddr   = cnt_m1[AW-1:0];
        div_start   = 1'b0;

        unique case (r_state)
            pse_pkg::S_IDLE: begin
                if (in_acc) begin
                    priority if (i_char_code == pse_pkg::CH_END) begin
                        n_unf   = r_unf | (r_count == '0);
                        n_state = pse_pkg::S_TOP;
                    end else if (is_digit) begin
                        if (full) begin
                            n_ovf = 1'b1;
                        end else begin
                            ram_we    = 1'b1;
                            ram_wdata = W'(i_char_code - pse_pkg::CH_DIGIT0);
                            n_count   = r_count + CW'(1);
                        end
                    end else if (is_op) begin
                        priority if (i_char_code == pse_pkg::CH_PLUS) begin
                            n_op = pse_pkg::OP_ADD;
                        end else if (i_char_code == pse_pkg::CH_MINUS) begin
                            n_op = pse_pkg::OP_SUB;
                        end else if (i_char_code == pse_pkg::CH_MUL) begin
                            n_op = pse_pkg::OP_MUL;
                        end else begin
                            n_op = pse_pkg::OP_DIV;
                        end
                        n_state = pse_pkg::S_OP_R;
                    end else begin
                        n_state = pse_pkg::S_IDLE;
                    end
                end
            end
            pse_pkg::S_OP_R: begin
                ram_raddr = cnt_m2[AW-1:0];
                n_right   = (r_count != '0) ? ram_rdata : pse_pkg::EMPTY_READ;
                n_state   = pse_pkg::S_OP_L;
            end
            pse_pkg::S_OP_L: begin
                n_left  = (r_count >= CW'(2)) ? ram_rdata : pse_pkg::EMPTY_READ;
                n_unf   = r_unf | (r_count < CW'(2));
                n_count = (r_count >= CW'(2)) ? cnt_m2 : '0;
                n_state = pse_pkg::S_EXEC;
            end
            pse_pkg::S_EXEC: begin
                n_state = pse_pkg::S_PUSH;
                unique case (r_op)
                    pse_pkg::OP_ADD: n_res = r_left + r_right;
                    pse_pkg::OP_SUB: n_res = r_left - r_right;
                    pse_pkg::OP_MUL: n_res = W'(r_left * r_right);
                    pse_pkg::OP_DIV: begin
                        if (r_right == '0) begin
                            n_res = '0;
                            n_dz  = 1'b1;
                        end else begin
                            div_start = 1'b1;
                            n_state   = pse_pkg::S_DIV;
                        end
                    end
                    default: n_res = r_res;
                endcase
            end
            pse_pkg::S_DIV: begin
                if (div_done) begin
                    n_res   = div_q;
                    n_state = pse_pkg::S_PUSH;
                end
            end
            pse_pkg::S_PUSH: begin
                if (full) begin
                    n_ovf = 1'b1;
                end else begin
                    ram_we  = 1'b1;
                    n_count = r_count + CW'(1);
                end
                n_state = pse_pkg::S_IDLE;
            end
            pse_pkg::S_TOP: begin
                n_res   = (r_count != '0) ? ram_rdata : pse_pkg::EMPTY_READ;
                n_state = pse_pkg::S_EMIT;
            end
            pse_pkg::S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_res;
                    n_out_ovf   = r_ovf;
                    n_out_unf   = r_unf;
                    n_out_dz    = r_dz;
                    n_count     = '0;
                    n_ovf       = 1'b0;
                    n_unf       = 1'b0;
                    n_dz        = 1'b0;
                    n_state     = pse_pkg::S_IDLE;
                end
            end
            default: n_state = pse_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pse_pkg::S_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_unf       <= 1'b0;
            r_dz        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_unf       <= n_unf;
            r_dz        <= n_dz;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_right     <= n_right;
        r_left      <= n_left;
        r_res       <= n_res;
        r_out_value <= n_out_value;
        r_out_ovf   <= n_out_ovf;
        r_out_unf   <= n_out_unf;
        r_out_dz    <= n_out_dz;
    end

    pse_ram #(
        .WIDTH (W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    pse_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_left),
        .i_divisor  (r_right),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign o_in_stall       = (r_state != pse_pkg::S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_value          = r_out_value;
    assign o_overflow_seen  = r_out_ovf;
    assign o_underflow_seen = r_out_unf;
    assign o_div_zero_seen  = r_out_dz;

endmodule

// File: design/pse_checker.sv
// ----------------------------------------------------------------------------
// pse_checker
// Port-level checks for the postfix stack evaluator: result beat hold and
// input stall behavior per character class.
// ----------------------------------------------------------------------------
module pse_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic [7:0]         i_char_code,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [31:0] o_value,
    input logic               o_overflow_seen,
    input logic               o_underflow_seen,
    input logic               o_div_zero_seen
);

    logic in_acc;
    logic acc_digit;
    logic acc_op;
    logic acc_end;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign acc_digit = in_acc && (i_char_code >= pse_pkg::CH_DIGIT0)
                    && (i_char_code <= pse_pkg::CH_DIGIT9);
    assign acc_op    = in_acc && ((i_char_code == pse_pkg::CH_PLUS)
                    || (i_char_code == pse_pkg::CH_MINUS)
                    || (i_char_code == pse_pkg::CH_MUL)
                    || (i_char_code == pse_pkg::CH_DIV));
    assign acc_end   = in_acc && (i_char_code == pse_pkg::CH_END);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_value)
            && $stable(o_overflow_seen) && $stable(o_underflow_seen)
            && $stable(o_div_zero_seen))
        else $error("result beat changed while stalled");

    a_digit_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_digit |=> !o_in_stall)
        else $error("digit beat did not free the input");

    a_op_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_op |=> o_in_stall ##1 o_in_stall)
        else $error("operator beat did not hold the input");

    a_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_end |=> o_in_stall)
        else $error("end beat did not hold the input");

endmodule

bind postfix_stack_evaluator pse_checker u_pse_checker (.*);

// File: sim/postfix_stack_evaluator_tb.sv
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_tb
// Feeds postfix character streams into the evaluator and predicts every result
// beat with a stack model of its own. Directed cases cover the operators,
// ignored characters, empty-stack reads, a full stack, division by zero and
// the most negative word divided by -1. Random expressions follow, most of
// them well formed and some broken or noisy, under three idle patterns.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator_tb;
    import pse_pkg::*;

    localparam int DEPTH           = DEF_STACK_DEPTH;
    localparam int STALL_LIMIT     = 4000;
    localparam int ITEMS_PER_PHASE = 600;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              overflow;
        logic              underflow;
        logic              div_zero;
    } eval_result_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [7:0]         i_char_code;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [31:0] o_value;
    logic               o_overflow_seen;
    logic               o_underflow_seen;
    logic               o_div_zero_seen;

    logic [DATA_W-1:0] operand_words [DEPTH];
    int unsigned       word_count = 0;
    logic              ovf_flag   = 1'b0;
    logic              unf_flag   = 1'b0;
    logic              dz_flag    = 1'b0;
    eval_result_t      pending_results [$];

    int send_idle_pct     = 0;
    int recv_idle_pct     = 0;
    int chars_sent        = 0;
    int results_checked   = 0;
    int overflow_results  = 0;
    int underflow_results = 0;
    int div_zero_results  = 0;
    int mismatch_count    = 0;
    int quiet_cycles      = 0;

    postfix_stack_evaluator #(
        .STACK_DEPTH(DEPTH)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_char_code     (i_char_code),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_value         (o_value),
        .o_overflow_seen (o_overflow_seen),
        .o_underflow_seen(o_underflow_seen),
        .o_div_zero_seen (o_div_zero_seen)
    );

    always #1 i_clk = ~i_clk;

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_DIGIT0 && c <= CH_DIGIT9;
    endfunction

    function automatic bit is_operator(input logic [7:0] c);
        return c == CH_PLUS || c == CH_MINUS || c == CH_MUL || c == CH_DIV;
    endfunction

    function automatic logic [DATA_W-1:0] read_top(input bit pop);
        logic [DATA_W-1:0] word;
        if (word_count == 0) begin
            unf_flag = 1'b1;
            return EMPTY_READ;
        end
        word = operand_words[word_count - 1];
        if (pop) word_count--;
        return word;
    endfunction

    function automatic void push_word(input logic [DATA_W-1:0] word);
        if (word_count >= DEPTH) begin
            ovf_flag = 1'b1;
        end else begin
            operand_words[word_count] = word;
            word_count++;
        end
    endfunction

    function automatic logic [DATA_W-1:0] divide_trunc(input logic [DATA_W-1:0] num,
                                                       input logic [DATA_W-1:0] den);
        logic [DATA_W-1:0] mag_num;
        logic [DATA_W-1:0] mag_den;
        logic [DATA_W-1:0] quo;
        if (den == '0) begin
            dz_flag = 1'b1;
            return '0;
        end
        mag_num = num[DATA_W-1] ? -num : num;
        mag_den = den[DATA_W-1] ? -den : den;
        quo     = mag_num / mag_den;
        return (num[DATA_W-1] ^ den[DATA_W-1]) ? -quo : quo;
    endfunction

    function automatic void evaluate_char(input logic [7:0] c);
        logic [DATA_W-1:0] rhs;
        logic [DATA_W-1:0] lhs;
        logic [DATA_W-1:0] res;
        if (c == CH_END) begin
            res = read_top(1'b0);
            pending_results.push_back('{value: res, overflow: ovf_flag,
                                        underflow: unf_flag, div_zero: dz_flag});
            word_count = 0;
            ovf_flag   = 1'b0;
            unf_flag   = 1'b0;
            dz_flag    = 1'b0;
        end else if (is_digit(c)) begin
            push_word(DATA_W'(c - CH_DIGIT0));
        end else if (is_operator(c)) begin
            rhs = read_top(1'b1);
            lhs = read_top(1'b1);
            case (c)
                CH_PLUS:  res = lhs + rhs;
                CH_MINUS: res = lhs - rhs;
                CH_MUL:   res = lhs * rhs;
                default:  res = divide_trunc(lhs, rhs);
            endcase
            push_word(res);
        end
    endfunction

    function automatic logic [7:0] random_operator();
        case ($urandom_range(3))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_MUL;
            default: return CH_DIV;
        endcase
    endfunction

    function automatic logic [7:0] random_noise_char();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (is_digit(c) || is_operator(c));
        return c;
    endfunction

    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_char_code <= c;
        do @(posedge i_clk); while (o_in_stall);
        evaluate_char(c);
        chars_sent++;
    endtask

    task automatic send_digit(input int n);
        send_char(CH_DIGIT0 + 8'(n));
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic note_mismatch(input string what, input logic signed [31:0] want,
                                 input logic signed [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    endtask

    task automatic check_result_beat();
        eval_result_t want;
        if (pending_results.size() == 0) begin
            note_mismatch("result beat with none pending", 'x, o_value);
            return;
        end
        want = pending_results.pop_front();
        results_checked++;
        if (want.overflow)  overflow_results++;
        if (want.underflow) underflow_results++;
        if (want.div_zero)  div_zero_results++;
        if (o_value !== want.value)
            note_mismatch("value", want.value, o_value);
        if (o_overflow_seen !== want.overflow)
            note_mismatch("overflow_seen", want.overflow, o_overflow_seen);
        if (o_underflow_seen !== want.underflow)
            note_mismatch("underflow_seen", want.underflow, o_underflow_seen);
        if (o_div_zero_seen !== want.div_zero)
            note_mismatch("div_zero_seen", want.div_zero, o_div_zero_seen);
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        if (i_rst_n && o_out_valid && !i_out_stall) check_result_beat();
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat for %0d cycles", STALL_LIMIT);
            $display("postfix_stack_evaluator_tb NOT OK");
            $finish;
        end
    end

    task automatic test_empty_end();
        send_char(CH_END);
    endtask

    task automatic test_operators();
        send_digit(3); send_digit(4); send_char(CH_PLUS);  send_char(CH_END);
        send_digit(5); send_digit(8); send_char(CH_MINUS); send_char(CH_END);
        send_digit(9); send_digit(7); send_char(CH_MUL);   send_char(CH_END);
        send_digit(8); send_digit(3); send_char(CH_DIV);   send_char(CH_END);
        // negative quotient truncates toward zero
        send_digit(0); send_digit(7); send_char(CH_MINUS);
        send_digit(2); send_char(CH_DIV); send_char(CH_END);
    endtask

    task automatic test_ignored_chars();
        send_digit(7);
        send_char(8'hFF);
        send_char(8'h01);
        send_char(8'h2C);
        send_char(8'h3A);
        send_char(8'h80);
        send_char(CH_END);
    endtask

    task automatic test_underflow();
        send_digit(5); send_char(CH_PLUS); send_char(CH_END);
        send_char(CH_PLUS); send_char(CH_END);
    endtask

    task automatic test_div_by_zero();
        send_digit(9); send_digit(0); send_char(CH_DIV); send_char(CH_END);
    endtask

    task automatic test_min_word_div();
        // build 8**10 * 2, which wraps to the most negative word, then divide by -1
        repeat (10) send_digit(8);
        repeat (9) send_char(CH_MUL);
        send_digit(2); send_char(CH_MUL);
        send_digit(0); send_digit(1); send_char(CH_MINUS);
        send_char(CH_DIV);
        send_char(CH_END);
    endtask

    task automatic test_overflow();
        repeat (DEPTH + 2) send_digit($urandom_range(9));
        send_char(CH_END);
    endtask

    task automatic send_random_expression();
        int kind;
        int digits;
        int depth;
        int pushed;
        kind = $urandom_range(99);
        if (kind < 3) begin
            repeat ($urandom_range(DEPTH - 4, DEPTH + 6)) send_digit($urandom_range(9));
            repeat ($urandom_range(3)) send_char(random_operator());
        end else if (kind < 15) begin
            repeat ($urandom_range(1, 10)) begin
                case ($urandom_range(2))
                    0:       send_digit($urandom_range(9));
                    1:       send_char(random_operator());
                    default: send_char(random_noise_char());
                endcase
            end
        end else begin
            digits = $urandom_range(1, 14);
            depth  = 0;
            pushed = 0;
            while (pushed < digits || depth > 1) begin
                if ($urandom_range(9) == 0) send_char(random_noise_char());
                if (pushed < digits && (depth < 2 || $urandom_range(1) == 1)) begin
                    send_digit($urandom_range(9));
                    depth++;
                    pushed++;
                end else begin
                    send_char(random_operator());
                    depth--;
                end
            end
        end
        send_char(CH_END);
    endtask

    task automatic test_random_expressions(input int target, input bit pause_midway);
        int first;
        bit paused;
        first  = chars_sent;
        paused = 1'b0;
        while (chars_sent - first < target) begin
            if (pause_midway && !paused && chars_sent - first >= target / 2) begin
                wait_for_results();
                paused = 1'b1;
            end
            send_random_expression();
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_char_code <= CH_END;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 21;
        recv_idle_pct = 75;
        test_empty_end();
        test_operators();
        test_ignored_chars();
        test_underflow();
        test_div_by_zero();
        test_min_word_div();
        test_overflow();
        test_random_expressions(ITEMS_PER_PHASE, 1'b0);

        send_idle_pct = 75;
        recv_idle_pct = 21;
        test_random_expressions(ITEMS_PER_PHASE, 1'b1);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_expressions(ITEMS_PER_PHASE, 1'b0);

        wait_for_results();
        repeat (60) @(posedge i_clk);

        $display("sent %0d characters, checked %0d results", chars_sent, results_checked);
        $display("results with overflow %0d, underflow %0d, divide by zero %0d",
                 overflow_results, underflow_results, div_zero_results);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("postfix_stack_evaluator_tb OK");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatch_count,
                     pending_results.size());
            $display("postfix_stack_evaluator_tb NOT OK");
        end
        $finish;
    end

endmodule

// File: postfix_stack_evaluator.f
design/pse_pkg.sv
design/pse_ram.sv
design/pse_div.sv
design/postfix_stack_evaluator.sv
design/pse_checker.sv
sim/postfix_stack_evaluator_tb.sv
